### design/modbus_sensor_response_parser_macros.svh
// Assertion macros shared by the Modbus sensor reply parser modules.
// No dependencies; included by the files that carry assertions.
`ifndef MODBUS_SENSOR_RESPONSE_PARSER_MACROS_SVH
`define MODBUS_SENSOR_RESPONSE_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MSRP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("msrp assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define MSRP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("msrp assertion failed");

`endif

### design/msrp_pkg.sv
// Types, codes and helper functions of the Modbus sensor reply parser.
// No dependencies; used by every other design file but the macro header.
package msrp_pkg;

    // Input opcodes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_TIMEOUT = 3'd1;
    localparam logic [2:0] ST_HEADER  = 3'd2;
    localparam logic [2:0] ST_CRC     = 3'd3;
    localparam logic [2:0] ST_RANGE   = 3'd4;

    // Configuration register indexes
    localparam int          CFG_IDX_W     = 2;
    localparam int          CFG_DATA_W    = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd1;

    // Reset values of the configuration registers
    localparam logic [7:0] SLAVE_ADDR_RST = 8'd1;
    localparam logic [9:0] TIMEOUT_RST    = 10'd300;

    // Frame layout
    localparam logic [3:0] FRAME_LEN     = 4'd9;
    localparam logic [3:0] CRC_BYTES     = 4'd7;
    localparam logic [7:0] FUNC_READ_HR  = 8'h03;
    localparam logic [7:0] BYTE_COUNT_EXP = 8'h04;

    // CRC-16, reflected form
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Plausible sensor range, tenths
    localparam logic        [15:0] HUM_MAX  = 16'd1000;
    localparam logic signed [15:0] TEMP_MIN = -16'sd400;
    localparam logic signed [15:0] TEMP_MAX = 16'sd850;

    // Classified command handed from front to back
    typedef enum logic [1:0] {
        KIND_START,
        KIND_BYTE,
        KIND_TICK
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } cmd_t;

    // One byte of the CRC, eight shift steps unrolled
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### design/msrp_intf.sv
// Channel interfaces of the Modbus sensor reply parser: input, result, config.
// Depends on msrp_pkg.
interface msrp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface msrp_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [15:0]        humidity_tenths;
    logic signed [15:0] temperature_tenths;
    logic [3:0]         bytes_received;

    modport source (output valid, output status, output humidity_tenths,
                    output temperature_tenths, output bytes_received, input ready);
    modport sink   (input valid, input status, input humidity_tenths,
                    input temperature_tenths, input bytes_received, output ready);
endinterface

interface msrp_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [msrp_pkg::CFG_IDX_W-1:0]     index;
    logic [msrp_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### design/modbus_sensor_response_parser.sv
// Modbus RTU soil sensor reply parser. Takes one beat per clock on req: a
// frame start, a received byte or a millisecond tick. The nine reply bytes are
// checked for address, function 3 and byte count 4, the CRC-16 over the first
// seven is compared with the last two, and humidity and signed temperature
// (tenths) are returned on rsp with a status: timeout, bad header, CRC error,
// out of range or ok, in that priority. A reply is closed by its ninth byte or
// by the tick that reaches timeout_ms. Throughput is one beat per cycle while the
// queue has room and the result register is free or read, set by the byte update of
// the frame engine (CRC step unrolled); a beat is held in the command queue before
// the engine takes it, and its result is registered before rsp. Config writes are
// taken at any time and must come only while no reply is in flight.
// Depends on msrp_pkg, the channel interfaces and the msrp_* submodules.
module modbus_sensor_response_parser #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    msrp_in_if.sink     req,
    msrp_cfg_if.sink    cfg,
    msrp_out_if.source  rsp
);
    import msrp_pkg::*;

    logic q_full;
    logic q_push;
    cmd_t push_cmd;
    logic q_pop;
    logic q_valid;
    cmd_t q_cmd;

    // Decode and admission
    msrp_front u_front (
        .req    (req),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (push_cmd)
    );

    // Decoupling queue
    msrp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    // Frame engine and result register
    msrp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .cfg     (cfg),
        .rsp     (rsp)
    );

endmodule

### design/msrp_front.sv
// Front end: accepts input beats, decodes the opcode and pushes commands.
// Depends on msrp_pkg and msrp_in_if.
module msrp_front (
    msrp_in_if.sink         req,
    input  logic            q_full,
    output logic            q_push,
    output msrp_pkg::cmd_t  q_cmd
);
    import msrp_pkg::*;

    logic keep;

    // Opcode decode; the unused opcode is accepted and dropped
    always_comb
    begin
        keep          = 1'b1;
        q_cmd.kind    = KIND_BYTE;
        q_cmd.data    = req.rx_byte;
        unique case (req.opcode)
            OP_START: q_cmd.kind = KIND_START;
            OP_BYTE:  q_cmd.kind = KIND_BYTE;
            OP_TICK:  q_cmd.kind = KIND_TICK;
            default:  keep = 1'b0;
        endcase
    end

    assign req.ready = !q_full;
    assign q_push    = req.valid && !q_full && keep;

endmodule

### design/msrp_queue.sv
// Small command FIFO between the front end and the frame engine.
// Depends on msrp_pkg and the assertion macro header.
`include "modbus_sensor_response_parser_macros.svh"

module msrp_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  msrp_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output msrp_pkg::cmd_t  q_cmd
);
    import msrp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = mem_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `MSRP_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))
    `MSRP_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !full)
    `MSRP_ASSERT_IMP(a_empty_ptrs, clk, rst_n, count_reg == '0, rd_ptr_reg == wr_ptr_reg)

endmodule

### design/msrp_back.sv
// Frame engine: config registers, reply state, CRC, checks and result register.
// Depends on msrp_pkg, msrp_out_if, msrp_cfg_if and the assertion macro header.
`include "modbus_sensor_response_parser_macros.svh"

module msrp_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  msrp_pkg::cmd_t  q_cmd,
    output logic            q_pop,
    msrp_cfg_if.sink        cfg,
    msrp_out_if.source      rsp
);
    import msrp_pkg::*;

    // Configuration
    logic [7:0]  slave_addr_reg;
    logic [9:0]  timeout_reg;

    // Reply state
    logic        active_reg,   active_next;
    logic [3:0]  count_reg,    count_next;
    logic [15:0] crc_reg,      crc_next;
    logic        hdr_ok_reg,   hdr_ok_next;
    logic [15:0] hum_reg,      hum_next;
    logic [15:0] temp_reg,     temp_next;
    logic [7:0]  crc_lo_reg,   crc_lo_next;
    logic [9:0]  elapsed_reg,  elapsed_next;

    // Result register
    logic               rsp_valid_reg;
    logic [2:0]         st_reg;
    logic [15:0]        hum_out_reg;
    logic signed [15:0] temp_out_reg;
    logic [3:0]         cnt_out_reg;

    logic               emit;
    logic [2:0]         res_st;
    logic [15:0]        res_hum;
    logic [15:0]        res_temp;
    logic [3:0]         res_cnt;
    logic [15:0]        crc_upd;
    logic               range_ok;

    // Configuration writes, always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg <= SLAVE_ADDR_RST;
            timeout_reg    <= TIMEOUT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_SLAVE_ADDR: slave_addr_reg <= cfg.data[7:0];
                CFG_TIMEOUT:    timeout_reg    <= cfg.data[9:0];
                default:        ;
            endcase
        end
    end

    // Take a command when the result register can absorb a beat
    assign q_pop    = q_valid && (!rsp_valid_reg || rsp.ready);
    assign crc_upd  = crc16_byte(crc_reg, q_cmd.data);
    assign range_ok = (hum_reg <= HUM_MAX) && ($signed(temp_reg) >= TEMP_MIN)
                      && ($signed(temp_reg) <= TEMP_MAX);

    // Command execution
    always_comb
    begin
        active_next  = active_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        hdr_ok_next  = hdr_ok_reg;
        hum_next     = hum_reg;
        temp_next    = temp_reg;
        crc_lo_next  = crc_lo_reg;
        elapsed_next = elapsed_reg;
        emit         = 1'b0;
        res_st       = ST_OK;
        res_hum      = '0;
        res_temp     = '0;
        res_cnt      = count_reg;

        if (q_pop)
        begin
            unique case (q_cmd.kind)
                KIND_START:
                begin
                    active_next  = 1'b1;
                    count_next   = '0;
                    crc_next     = CRC_INIT;
                    hdr_ok_next  = 1'b1;
                    hum_next     = '0;
                    temp_next    = '0;
                    crc_lo_next  = '0;
                    elapsed_next = '0;
                end
                KIND_TICK:
                begin
                    if (active_reg)
                    begin
                        elapsed_next = elapsed_reg + 10'd1;
                        if (elapsed_next >= timeout_reg)
                        begin
                            emit        = 1'b1;
                            res_st      = ST_TIMEOUT;
                            active_next = 1'b0;
                        end
                    end
                end
                KIND_BYTE:
                begin
                    if (active_reg)
                    begin
                        unique case (count_reg)
                            4'd0: if (q_cmd.data != slave_addr_reg) hdr_ok_next = 1'b0;
                            4'd1: if (q_cmd.data != FUNC_READ_HR)   hdr_ok_next = 1'b0;
                            4'd2: if (q_cmd.data != BYTE_COUNT_EXP) hdr_ok_next = 1'b0;
                            4'd3: hum_next  = {q_cmd.data, 8'h00};
                            4'd4: hum_next  = {hum_reg[15:8], q_cmd.data};
                            4'd5: temp_next = {q_cmd.data, 8'h00};
                            4'd6: temp_next = {temp_reg[15:8], q_cmd.data};
                            4'd7: crc_lo_next = q_cmd.data;
                            default: ;
                        endcase
                        if (count_reg < CRC_BYTES)
                        begin
                            crc_next = crc_upd;
                        end
                        count_next = count_reg + 4'd1;

                        // Last byte closes the reply
                        if (count_next == FRAME_LEN)
                        begin
                            emit        = 1'b1;
                            active_next = 1'b0;
                            res_cnt     = FRAME_LEN;
                            priority if (!hdr_ok_reg)
                            begin
                                res_st = ST_HEADER;
                            end
                            else if (crc_reg != {q_cmd.data, crc_lo_reg})
                            begin
                                res_st = ST_CRC;
                            end
                            else
                            begin
                                res_st   = range_ok ? ST_OK : ST_RANGE;
                                res_hum  = hum_reg;
                                res_temp = temp_reg;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Reply state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            count_reg   <= '0;
            crc_reg     <= CRC_INIT;
            hdr_ok_reg  <= 1'b1;
            hum_reg     <= '0;
            temp_reg    <= '0;
            crc_lo_reg  <= '0;
            elapsed_reg <= '0;
        end
        else
        begin
            active_reg  <= active_next;
            count_reg   <= count_next;
            crc_reg     <= crc_next;
            hdr_ok_reg  <= hdr_ok_next;
            hum_reg     <= hum_next;
            temp_reg    <= temp_next;
            crc_lo_reg  <= crc_lo_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            st_reg       <= res_st;
            hum_out_reg  <= res_hum;
            temp_out_reg <= $signed(res_temp);
            cnt_out_reg  <= res_cnt;
        end
    end

    assign rsp.valid              = rsp_valid_reg;
    assign rsp.status             = st_reg;
    assign rsp.humidity_tenths    = hum_out_reg;
    assign rsp.temperature_tenths = temp_out_reg;
    assign rsp.bytes_received     = cnt_out_reg;

    `MSRP_ASSERT_IMP(a_emit_active, clk, rst_n, emit, active_reg && q_pop)
    `MSRP_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= FRAME_LEN)
    `MSRP_ASSERT_NXT(a_full_frame, clk, rst_n, emit && res_st != ST_TIMEOUT,
        rsp_valid_reg && cnt_out_reg == FRAME_LEN && !active_reg)
    `MSRP_ASSERT_IMP(a_zero_fields, clk, rst_n,
        rsp_valid_reg && (st_reg == ST_TIMEOUT || st_reg == ST_HEADER || st_reg == ST_CRC),
        hum_out_reg == '0 && temp_out_reg == '0)

endmodule
